/* src/kdes_pkg.sv */
// Shared types, constants and field layout for the lattice exchange block.
package kdes_pkg;

   // Grid size defaults
   localparam int GRID_ROWS_DEF    = 64;
   localparam int GRID_COLUMNS_DEF = 64;

   // Field widths
   localparam int OP_W        = 2;
   localparam int SITE_W      = 6;
   localparam int DIR_W       = 2;
   localparam int CHANCE_W    = 16;
   localparam int FACTOR_W    = 32;
   localparam int PROD_W      = 2 * FACTOR_W;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 8;

   // Request word layout
   localparam int ROW_LSB    = 0;
   localparam int COL_LSB    = ROW_LSB + SITE_W;
   localparam int DIR_LSB    = COL_LSB + SITE_W;
   localparam int CHANCE_LSB = DIR_LSB + DIR_W;
   localparam int WV_BIT     = CHANCE_LSB + CHANCE_W;

   // Response word layout
   localparam int OCC_BIT   = 0;
   localparam int ACC_BIT   = 1;
   localparam int DRIFT_BIT = 2;

   // Register file
   localparam int NUM_REGS   = 8;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);
   localparam int CSR_ADDR_W = REG_IDX_W + 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [REG_IDX_W-1:0] REG_CPL_M6        = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CPL_M4        = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CPL_M2        = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CPL_P2        = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CPL_P4        = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CPL_P6        = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_FIELD_WITH    = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_FIELD_AGAINST = 3'd7;

   localparam logic [FACTOR_W-1:0] ONE_Q16 = 32'h0001_0000;

   // Operation codes
   localparam logic [OP_W-1:0] OP_EXCHANGE = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE    = 2'd1;
   localparam logic [OP_W-1:0] OP_READ     = 2'd2;

   // Hop directions
   localparam logic [DIR_W-1:0] DIR_RIGHT   = 2'd0;
   localparam logic [DIR_W-1:0] DIR_WITH    = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT    = 2'd2;
   localparam logic [DIR_W-1:0] DIR_AGAINST = 2'd3;

   // Half bond sums (bond sum divided by two)
   localparam logic signed [3:0] BOND_M6 = -4'sd3;
   localparam logic signed [3:0] BOND_M4 = -4'sd2;
   localparam logic signed [3:0] BOND_M2 = -4'sd1;
   localparam logic signed [3:0] BOND_P2 = 4'sd1;
   localparam logic signed [3:0] BOND_P4 = 4'sd2;
   localparam logic signed [3:0] BOND_P6 = 4'sd3;

   // Row buffer slots: rows r-2 .. r+2
   localparam int NUM_SLOTS = 5;
   localparam int SLOT_W    = 3;

   typedef logic [NUM_REGS-1:0][FACTOR_W-1:0] factor_bank_type;

   // Request to the shared multiply and compare unit
   typedef struct packed {
      logic                start;
      logic [FACTOR_W-1:0] coupling;
      logic [FACTOR_W-1:0] field;
      logic [CHANCE_W-1:0] chance;
   } mul_req_type;

endpackage

/* src/kdes_csr.sv */
// Configuration register file with a write and read bus port.
module kdes_csr import kdes_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output factor_bank_type       regs
);

   factor_bank_type regs_ff;
   factor_bank_type regs_in;
   logic [REG_IDX_W-1:0] idx;

   assign idx = csr_paddr[CSR_ADDR_W-1:2];

   // Update the addressed register on a completed write
   always_comb begin
      regs_in = regs_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         regs_in[idx] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= {NUM_REGS{ONE_Q16}};
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_prdata = regs_ff[idx];
   assign regs       = regs_ff;

endmodule

/* src/kdes_grid.sv */
// Row-wide occupancy memory: one write and one registered read per cycle.
module kdes_grid import kdes_pkg::*; #(
   parameter  int GRID_ROWS    = GRID_ROWS_DEF,
   parameter  int GRID_COLUMNS = GRID_COLUMNS_DEF,
   localparam int ROW_W        = $clog2(GRID_ROWS)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ROW_W-1:0]        wr_addr,
   input  logic [GRID_COLUMNS-1:0] wr_data,
   input  logic                    rd_en,
   input  logic [ROW_W-1:0]        rd_addr,
   output logic [GRID_COLUMNS-1:0] rd_data
);

   logic [GRID_COLUMNS-1:0] mem [GRID_ROWS];
   logic [GRID_COLUMNS-1:0] rd_data_ff;

   // Write one row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one row, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/kdes_mul.sv */
// Shared multiply and compare unit for the acceptance test.
module kdes_mul import kdes_pkg::*; (
   input  logic        clock,
   input  mul_req_type req,
   output logic        accept
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [PROD_W-1:0] limit;

   // Form the exact Q32.32 product of the two factors
   always_comb begin
      prod_in = prod_ff;
      if (req.start) begin
         prod_in = PROD_W'(req.coupling) * PROD_W'(req.field);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Chance moved to Q32.32; equality accepts
   assign limit  = {{(PROD_W - CHANCE_W - 16){1'b0}}, req.chance, 16'b0};
   assign accept = (prod_ff >= limit);

endmodule

/* src/kdes_seq.sv */
// Sequencer: clearing pass, row fetch, bond sum, acceptance and row write-back.
module kdes_seq import kdes_pkg::*; #(
   parameter  int GRID_ROWS    = GRID_ROWS_DEF,
   parameter  int GRID_COLUMNS = GRID_COLUMNS_DEF,
   localparam int ROW_W        = $clog2(GRID_ROWS),
   localparam int COL_W        = $clog2(GRID_COLUMNS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [OP_W-1:0]         req_tuser,
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input  factor_bank_type         regs,
   output mul_req_type             mul_req,
   input  logic                    mul_accept,
   output logic                    mem_wr_en,
   output logic [ROW_W-1:0]        mem_wr_addr,
   output logic [GRID_COLUMNS-1:0] mem_wr_data,
   output logic                    mem_rd_en,
   output logic [ROW_W-1:0]        mem_rd_addr,
   input  logic [GRID_COLUMNS-1:0] mem_rd_data
);

   // Fold registers hold the raw coordinate and the grid size
   localparam int RED_RW = (ROW_W + 1 > SITE_W) ? ROW_W + 1 : SITE_W;
   localparam int RED_CW = (COL_W + 1 > SITE_W) ? COL_W + 1 : SITE_W;
   localparam logic [RED_RW-1:0] ROWS_R = RED_RW'(GRID_ROWS);
   localparam logic [RED_CW-1:0] COLS_R = RED_CW'(GRID_COLUMNS);
   localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(GRID_ROWS - 1);
   localparam logic [COL_W-1:0]  COL_LAST = COL_W'(GRID_COLUMNS - 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

   // States
   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_REDUCE  = 4'd2;
   localparam logic [3:0] ST_READ    = 4'd3;
   localparam logic [3:0] ST_SETTLE  = 4'd4;
   localparam logic [3:0] ST_EVAL    = 4'd5;
   localparam logic [3:0] ST_MUL     = 4'd6;
   localparam logic [3:0] ST_CMP     = 4'd7;
   localparam logic [3:0] ST_WR_SITE = 4'd8;
   localparam logic [3:0] ST_WR_PART = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   function automatic logic [ROW_W-1:0] row_up(input logic [ROW_W-1:0] r);
      return (r == '0) ? ROW_LAST : r - ROW_W'(1);
   endfunction

   function automatic logic [ROW_W-1:0] row_down(input logic [ROW_W-1:0] r);
      return (r == ROW_LAST) ? '0 : r + ROW_W'(1);
   endfunction

   function automatic logic [COL_W-1:0] col_left(input logic [COL_W-1:0] c);
      return (c == '0) ? COL_LAST : c - COL_W'(1);
   endfunction

   function automatic logic [COL_W-1:0] col_right(input logic [COL_W-1:0] c);
      return (c == COL_LAST) ? '0 : c + COL_W'(1);
   endfunction

   logic [3:0]              state_ff, state_in;
   logic [ROW_W-1:0]        cnt_ff, cnt_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [DIR_W-1:0]        dir_ff, dir_in;
   logic [CHANCE_W-1:0]     chance_ff, chance_in;
   logic                    wv_ff, wv_in;
   logic [RED_RW-1:0]       red_row_ff, red_row_in;
   logic [RED_CW-1:0]       red_col_ff, red_col_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic                    rd_pend_ff;
   logic [SLOT_W-1:0]       rd_slot_ff;
   logic [GRID_COLUMNS-1:0] rowbuf_ff [NUM_SLOTS];
   logic                    cur_ff, cur_in;
   logic                    vert_ff, vert_in;
   logic                    down_ff, down_in;
   logic [COL_W-1:0]        pc_ff, pc_in;
   logic [FACTOR_W-1:0]     coupling_ff, coupling_in;
   logic [FACTOR_W-1:0]     field_ff, field_in;
   logic                    swap_ff, swap_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [ROW_W-1:0]        row, rm1, rm2, rp1, rp2, part_row;
   logic [COL_W-1:0]        col, cl, cr;
   logic                    cur, vert, down, differ, part_val;
   logic [COL_W-1:0]        pc;
   logic [GRID_COLUMNS-1:0] pa, pm, pb;
   logic [2:0]              n_site, n_part;
   logic signed [3:0]       diff_n, half_bond;
   logic [FACTOR_W-1:0]     coupling, field;
   logic [GRID_COLUMNS-1:0] site_new, part_new;
   logic                    out_free;

   // Folded coordinates and their neighbor rows and columns
   assign row = red_row_ff[ROW_W-1:0];
   assign col = red_col_ff[COL_W-1:0];
   assign rm1 = row_up(row);
   assign rm2 = row_up(rm1);
   assign rp1 = row_down(row);
   assign rp2 = row_down(rp1);
   assign cl  = col_left(col);
   assign cr  = col_right(col);

   // Locate the partner and form the half bond sum from the buffered rows
   always_comb begin
      cur  = rowbuf_ff[2][col];
      vert = 1'b0;
      down = 1'b0;
      pc   = col;
      case (dir_ff)
         DIR_RIGHT: pc = cr;
         DIR_LEFT:  pc = cl;
         DIR_WITH: begin
            vert = 1'b1;
            down = cur;
         end
         DIR_AGAINST: begin
            vert = 1'b1;
            down = ~cur;
         end
         default: pc = col;
      endcase

      if (!vert) begin
         pa = rowbuf_ff[1];
         pm = rowbuf_ff[2];
         pb = rowbuf_ff[3];
      end else if (down) begin
         pa = rowbuf_ff[2];
         pm = rowbuf_ff[3];
         pb = rowbuf_ff[4];
      end else begin
         pa = rowbuf_ff[0];
         pm = rowbuf_ff[1];
         pb = rowbuf_ff[2];
      end

      part_val = pm[pc];
      differ   = (part_val != cur);

      n_site = {2'b00, rowbuf_ff[1][col]} + {2'b00, rowbuf_ff[3][col]} +
               {2'b00, rowbuf_ff[2][cl]}  + {2'b00, rowbuf_ff[2][cr]};
      n_part = {2'b00, pa[pc]} + {2'b00, pb[pc]} +
               {2'b00, pm[col_left(pc)]} + {2'b00, pm[col_right(pc)]};
      diff_n    = $signed({1'b0, n_site}) - $signed({1'b0, n_part});
      half_bond = 4'sd1 + (cur ? diff_n : -diff_n);

      case (half_bond)
         BOND_M6: coupling = regs[REG_CPL_M6];
         BOND_M4: coupling = regs[REG_CPL_M4];
         BOND_M2: coupling = regs[REG_CPL_M2];
         BOND_P2: coupling = regs[REG_CPL_P2];
         BOND_P4: coupling = regs[REG_CPL_P4];
         BOND_P6: coupling = regs[REG_CPL_P6];
         default: coupling = ONE_Q16;
      endcase

      case (dir_ff)
         DIR_WITH:    field = regs[REG_FIELD_WITH];
         DIR_AGAINST: field = regs[REG_FIELD_AGAINST];
         default:     field = ONE_Q16;
      endcase
   end

   // Build the rows to write back
   always_comb begin
      site_new = rowbuf_ff[2];
      if (op_ff == OP_WRITE) begin
         site_new[col] = wv_ff;
      end else begin
         site_new[col] = ~rowbuf_ff[2][col];
         if (!vert_ff) begin
            site_new[pc_ff] = ~rowbuf_ff[2][pc_ff];
         end
      end
      part_new      = down_ff ? rowbuf_ff[3] : rowbuf_ff[1];
      part_new[col] = ~part_new[col];
      part_row      = down_ff ? rp1 : rm1;
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      op_in       = op_ff;
      dir_in      = dir_ff;
      chance_in   = chance_ff;
      wv_in       = wv_ff;
      red_row_in  = red_row_ff;
      red_col_in  = red_col_ff;
      slot_in     = slot_ff;
      cur_in      = cur_ff;
      vert_in     = vert_ff;
      down_in     = down_ff;
      pc_in       = pc_ff;
      coupling_in = coupling_ff;
      field_in    = field_ff;
      swap_in     = swap_ff;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + ROW_W'(1);
            if (cnt_ff == ROW_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tuser;
               dir_in     = req_tdata[DIR_LSB +: DIR_W];
               chance_in  = req_tdata[CHANCE_LSB +: CHANCE_W];
               wv_in      = req_tdata[WV_BIT];
               red_row_in = RED_RW'(req_tdata[ROW_LSB +: SITE_W]);
               red_col_in = RED_CW'(req_tdata[COL_LSB +: SITE_W]);
               swap_in    = 1'b0;
               state_in   = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            // Fold the coordinates into the grid one subtraction a cycle
            if (red_row_ff >= ROWS_R) begin
               red_row_in = red_row_ff - ROWS_R;
            end
            if (red_col_ff >= COLS_R) begin
               red_col_in = red_col_ff - COLS_R;
            end
            if (red_row_ff < ROWS_R && red_col_ff < COLS_R) begin
               slot_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            slot_in = slot_ff + SLOT_W'(1);
            if (slot_ff == SLOT_LAST) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: state_in = ST_EVAL;
         ST_EVAL: begin
            cur_in      = cur;
            vert_in     = vert;
            down_in     = down;
            pc_in       = pc;
            coupling_in = coupling;
            field_in    = field;
            case (op_ff)
               OP_EXCHANGE: state_in = differ ? ST_MUL : ST_DONE;
               OP_WRITE:    state_in = ST_WR_SITE;
               default:     state_in = ST_DONE;
            endcase
         end
         ST_MUL: state_in = ST_CMP;
         ST_CMP: begin
            if (mul_accept) begin
               swap_in  = 1'b1;
               state_in = ST_WR_SITE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WR_SITE: begin
            state_in = (op_ff == OP_EXCHANGE && vert_ff) ? ST_WR_PART : ST_DONE;
         end
         ST_WR_PART: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result register: load when it is empty or its word is being taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in             = '0;
         rsp_data_in[OCC_BIT]    = cur_ff;
         rsp_data_in[ACC_BIT]    = swap_ff;
         rsp_data_in[DRIFT_BIT]  = swap_ff && (dir_ff == DIR_WITH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         swap_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= (state_ff == ST_READ);
         swap_ff      <= swap_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      dir_ff      <= dir_in;
      chance_ff   <= chance_in;
      wv_ff       <= wv_in;
      red_row_ff  <= red_row_in;
      red_col_ff  <= red_col_in;
      slot_ff     <= slot_in;
      rd_slot_ff  <= slot_ff;
      cur_ff      <= cur_in;
      vert_ff     <= vert_in;
      down_ff     <= down_in;
      pc_ff       <= pc_in;
      coupling_ff <= coupling_in;
      field_ff    <= field_in;
      rsp_data_ff <= rsp_data_in;
      // Capture each fetched row into its slot
      if (rd_pend_ff) begin
         rowbuf_ff[rd_slot_ff] <= mem_rd_data;
      end
   end

   // Memory read address per slot: rows r-2 .. r+2
   always_comb begin
      case (slot_ff)
         3'd0:    mem_rd_addr = rm2;
         3'd1:    mem_rd_addr = rm1;
         3'd2:    mem_rd_addr = row;
         3'd3:    mem_rd_addr = rp1;
         default: mem_rd_addr = rp2;
      endcase
   end
   assign mem_rd_en = (state_ff == ST_READ);

   // Memory write: clearing pass, site row, partner row
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = cnt_ff;
      mem_wr_data = '0;
      case (state_ff)
         ST_CLEAR: mem_wr_en = 1'b1;
         ST_WR_SITE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = row;
            mem_wr_data = site_new;
         end
         ST_WR_PART: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = part_row;
            mem_wr_data = part_new;
         end
         default: mem_wr_en = 1'b0;
      endcase
   end

   // Multiply request
   always_comb begin
      mul_req.start    = (state_ff == ST_MUL);
      mul_req.coupling = coupling_ff;
      mul_req.field    = field_ff;
      mul_req.chance   = chance_ff;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* src/kawasaki_driven_exchange_step.sv */
// Top level of the driven lattice-gas exchange block.
//
//  Channel   Dir  Handshake          Payload
//  req_      in   tvalid / tready    tuser: opcode; tdata: site, hop, chance, write value
//  rsp_      out  tvalid / tready    tdata: site_occupied, exchange_accepted, drift_hop
//  csr_      in   psel/penable/pready 8 x 32-bit factor registers at byte address 4*i
//
// An item runs accept, fold, five row reads through the grid memory's read port, a settle
// state for the read latency, evaluate, then the result load. A write adds its site row
// write. An exchange of unlike sites adds the multiply and compare; when accepted it adds
// the site row write and, for a vertical hop, the partner row write.
// Coordinates past the grid stay in the fold state until subtracting the grid size brings them inside.
// After reset a clearing pass writes every row to holes; req_tready stays low meanwhile.
// The result register holds a word until taken; a new word is accepted meanwhile, and a
// finished item waits only if the previous word is still held.
module kawasaki_driven_exchange_step import kdes_pkg::*; #(
   parameter int GRID_ROWS    = GRID_ROWS_DEF,
   parameter int GRID_COLUMNS = GRID_COLUMNS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [OP_W-1:0]        req_tuser,   // [1:0] opcode
   // [5:0] site_row, [11:6] site_column, [13:12] hop_direction,
   // [29:14] random_chance, [30] write_occupied, [31] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] site_occupied, [1] exchange_accepted, [2] drift_hop, [7:3] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // Configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int ROW_W = $clog2(GRID_ROWS);

   factor_bank_type         regs;
   mul_req_type             mul_req;
   logic                    mul_accept;
   logic                    mem_wr_en;
   logic [ROW_W-1:0]        mem_wr_addr;
   logic [GRID_COLUMNS-1:0] mem_wr_data;
   logic                    mem_rd_en;
   logic [ROW_W-1:0]        mem_rd_addr;
   logic [GRID_COLUMNS-1:0] mem_rd_data;

   assign csr_pready = 1'b1;

   kdes_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .regs        (regs)
   );

   kdes_grid #(
      .GRID_ROWS    (GRID_ROWS),
      .GRID_COLUMNS (GRID_COLUMNS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   kdes_mul u_mul (
      .clock  (clock),
      .req    (mul_req),
      .accept (mul_accept)
   );

   kdes_seq #(
      .GRID_ROWS    (GRID_ROWS),
      .GRID_COLUMNS (GRID_COLUMNS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .regs        (regs),
      .mul_req     (mul_req),
      .mul_accept  (mul_accept),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule

/* src/kdes_check.sv */
// Port-level checker for the exchange block and its bind.
module kdes_check import kdes_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Drop ready for the whole item once a word is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready high right after an accepted word");

   // A drift hop is always an accepted swap
   a_drift_implies_swap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[DRIFT_BIT] || rsp_tdata[ACC_BIT]))
      else $error("drift hop flagged without a swap");

   // Clearing pass keeps the input closed and no result pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block active right after reset");

endmodule

bind kawasaki_driven_exchange_step kdes_check u_kdes_check (.*);

/* sim/tb.sv */
// Self-checking testbench for the driven lattice-gas exchange block.
`timescale 1ns / 100ps

module tb;
   import kdes_pkg::*;

   localparam int ROWS           = GRID_ROWS_DEF;
   localparam int COLS           = GRID_COLUMNS_DEF;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int NUM_PHASES     = 6;
   localparam int ITEMS_PER_PHASE = 205;
   // Opcode 3 is unassigned and behaves as a read
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]     opcode;
      logic [SITE_W-1:0]   site_row;
      logic [SITE_W-1:0]   site_column;
      logic [DIR_W-1:0]    hop;
      logic [CHANCE_W-1:0] chance;
      logic                write_value;
   } site_request_type;

   typedef struct packed {
      logic site_occupied;
      logic exchange_accepted;
      logic drift_hop;
   } site_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [OP_W-1:0]        req_tuser = '0;   // [1:0] opcode
   // [5:0] site_row, [11:6] site_column, [13:12] hop_direction,
   // [29:14] random_chance, [30] write_occupied, [31] zero
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [0] site_occupied, [1] exchange_accepted, [2] drift_hop, [7:3] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // Shadow copies of the block's registers and grid
   logic [FACTOR_W-1:0] factor_bank [NUM_REGS] = '{default: ONE_Q16};
   bit                  lattice_model [ROWS][COLS];

   site_request_type queued_site_requests [$];
   site_result_type  awaited_site_results [$];
   site_request_type word_on_bus;

   int mismatch_count = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int sender_gap_max = 0;
   int stall_left = 0;
   int ready_run_left = 0;
   int receiver_stall_max = 0;

   int gap_limit_by_phase [NUM_PHASES]   = '{0, 6, 20, 0, 3, 12};
   int stall_limit_by_phase [NUM_PHASES] = '{0, 3, 0, 30, 8, 12};

   kawasaki_driven_exchange_step dut (.*);

   always #5 clock = ~clock;

   function automatic int spin_at(input int r, input int c);
      return lattice_model[r][c] ? 1 : -1;
   endfunction

   function automatic int neighbor_spin_sum(input int r, input int c);
      return spin_at((r + ROWS - 1) % ROWS, c) + spin_at((r + 1) % ROWS, c) +
             spin_at(r, (c + COLS - 1) % COLS) + spin_at(r, (c + 1) % COLS);
   endfunction

   function automatic logic [FACTOR_W-1:0] coupling_for_bond(input int bond);
      case (bond)
         -6:      return factor_bank[REG_CPL_M6];
         -4:      return factor_bank[REG_CPL_M4];
         -2:      return factor_bank[REG_CPL_M2];
         2:       return factor_bank[REG_CPL_P2];
         4:       return factor_bank[REG_CPL_P4];
         6:       return factor_bank[REG_CPL_P6];
         default: return ONE_Q16;
      endcase
   endfunction

   // Apply one request to the shadow grid and return the word it should produce
   function automatic site_result_type apply_site_request(input site_request_type req);
      int r, c, pr, pc, s_here, s_there, bond;
      logic here;
      logic [FACTOR_W-1:0] field;
      logic [PROD_W-1:0] weight;
      site_result_type res;
      r = int'(req.site_row) % ROWS;
      c = int'(req.site_column) % COLS;
      here = lattice_model[r][c];
      res.site_occupied = here;
      res.exchange_accepted = 1'b0;
      res.drift_hop = 1'b0;
      case (req.opcode)
         OP_WRITE: lattice_model[r][c] = req.write_value;
         OP_EXCHANGE: begin
            pr = r;
            pc = c;
            case (req.hop)
               DIR_RIGHT: pc = (c + 1) % COLS;
               DIR_LEFT:  pc = (c + COLS - 1) % COLS;
               // particles fall with the field, holes rise
               DIR_WITH:  pr = here ? (r + 1) % ROWS : (r + ROWS - 1) % ROWS;
               default:   pr = here ? (r + ROWS - 1) % ROWS : (r + 1) % ROWS;
            endcase
            if (lattice_model[pr][pc] != here) begin
               s_here = spin_at(r, c);
               s_there = spin_at(pr, pc);
               bond = (neighbor_spin_sum(r, c) - s_there) * s_here +
                      (neighbor_spin_sum(pr, pc) - s_here) * s_there;
               if (req.hop == DIR_WITH)
                  field = factor_bank[REG_FIELD_WITH];
               else if (req.hop == DIR_AGAINST)
                  field = factor_bank[REG_FIELD_AGAINST];
               else
                  field = ONE_Q16;
               weight = {32'd0, coupling_for_bond(bond)} * {32'd0, field};
               // exact Q32.32 compare, equality accepts
               if (weight >= {32'd0, req.chance, 16'd0}) begin
                  lattice_model[r][c] = lattice_model[pr][pc];
                  lattice_model[pr][pc] = here;
                  res.exchange_accepted = 1'b1;
                  res.drift_hop = (req.hop == DIR_WITH);
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic site_request_type make_request(input logic [OP_W-1:0] op,
                                                     input int r, input int c,
                                                     input logic [DIR_W-1:0] hop,
                                                     input logic [CHANCE_W-1:0] chance,
                                                     input logic wv);
      site_request_type req;
      req.opcode = op;
      req.site_row = SITE_W'(r);
      req.site_column = SITE_W'(c);
      req.hop = hop;
      req.chance = chance;
      req.write_value = wv;
      return req;
   endfunction

   // Append one request word to the pending list
   task automatic enqueue_request(input site_request_type req);
      queued_site_requests = {queued_site_requests, req};
   endtask

   // Drive request words in bursts; predict each word as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            awaited_site_results = {awaited_site_results, apply_site_request(word_on_bus)};
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || queued_site_requests.size() == 0) begin
               req_tvalid <= 1'b0;
               if (gap_left > 0)
                  gap_left--;
            end else begin
               word_on_bus = queued_site_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= word_on_bus.opcode;
               req_tdata <= {1'b0, word_on_bus.write_value, word_on_bus.chance, word_on_bus.hop,
                             word_on_bus.site_column, word_on_bus.site_row};
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = (sender_gap_max > 0) ? $urandom_range(0, sender_gap_max) : 0;
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   task automatic check_bit(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Take result words under a stall pattern and compare with the oldest prediction
   always @(posedge clock) begin
      site_result_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (awaited_site_results.size() == 0) begin
            $error("result word %h with no request outstanding", rsp_tdata);
            mismatch_count++;
         end else begin
            want = awaited_site_results.pop_front();
            check_bit("site_occupied", want.site_occupied, rsp_tdata[OCC_BIT]);
            check_bit("exchange_accepted", want.exchange_accepted, rsp_tdata[ACC_BIT]);
            check_bit("drift_hop", want.drift_hop, rsp_tdata[DRIFT_BIT]);
         end
      end
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (ready_run_left > 0) begin
            ready_run_left--;
         end else begin
            ready_run_left = $urandom_range(0, 12);
            stall_left = (receiver_stall_max > 0) ? $urandom_range(1, receiver_stall_max) : 0;
         end
      end
   end

   // End the run when no word moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic write_factor(input logic [REG_IDX_W-1:0] idx, input logic [FACTOR_W-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      factor_bank[idx] = value;
   endtask

   task automatic program_factors(input logic [FACTOR_W-1:0] m6, m4, m2, p2, p4, p6,
                                  input logic [FACTOR_W-1:0] with_field, against_field);
      write_factor(REG_CPL_M6, m6);
      write_factor(REG_CPL_M4, m4);
      write_factor(REG_CPL_M2, m2);
      write_factor(REG_CPL_P2, p2);
      write_factor(REG_CPL_P4, p4);
      write_factor(REG_CPL_P6, p6);
      write_factor(REG_FIELD_WITH, with_field);
      write_factor(REG_FIELD_AGAINST, against_field);
   endtask

   // Wait until every predicted word has come back, then let the block go quiet
   task automatic settle_block();
      while (queued_site_requests.size() != 0 || req_tvalid || awaited_site_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random traffic concentrated in a small window so neighbors interact
   task automatic queue_random_items(input int count);
      int n, k, win_row, win_col, win_span, pick;
      site_request_type req;
      n = 0;
      while (n < count) begin
         if (n % 60 == 0) begin
            win_row = $urandom_range(0, ROWS - 1);
            win_col = $urandom_range(0, COLS - 1);
            win_span = $urandom_range(3, 6);
            // seed the new window with a random pattern
            for (k = 0; k < 2 * win_span && n < count; k++) begin
               enqueue_request(make_request(OP_WRITE,
                  (win_row + $urandom_range(0, win_span - 1)) % ROWS,
                  (win_col + $urandom_range(0, win_span - 1)) % COLS,
                  DIR_W'($urandom), CHANCE_W'($urandom), 1'($urandom)));
               n++;
            end
         end
         pick = $urandom_range(0, 99);
         req.site_row = SITE_W'((win_row + $urandom_range(0, win_span - 1)) % ROWS);
         req.site_column = SITE_W'((win_col + $urandom_range(0, win_span - 1)) % COLS);
         req.hop = DIR_W'($urandom);
         req.write_value = 1'($urandom);
         case ($urandom_range(0, 7))
            0:       req.chance = '0;
            1:       req.chance = '1;
            default: req.chance = CHANCE_W'($urandom);
         endcase
         if (pick < 20) begin
            req.opcode = OP_WRITE;
         end else if (pick < 88) begin
            req.opcode = OP_EXCHANGE;
         end else if (pick < 95) begin
            req.opcode = OP_READ;
         end else begin
            // noise anywhere on the grid, unassigned opcode included
            req.opcode = OP_W'($urandom_range(0, 3));
            req.site_row = SITE_W'($urandom);
            req.site_column = SITE_W'($urandom);
         end
         enqueue_request(req);
         n++;
      end
   endtask

   initial begin
      int phase;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: wraparound on every edge, both field directions, equal pairs
      enqueue_request(make_request(OP_READ, 0, 0, DIR_RIGHT, 16'h0000, 1'b0));
      enqueue_request(make_request(OP_UNUSED, 63, 63, DIR_AGAINST, 16'hFFFF, 1'b1));
      enqueue_request(make_request(OP_WRITE, 0, 63, DIR_AGAINST, 16'hFFFF, 1'b1));
      enqueue_request(make_request(OP_EXCHANGE, 0, 63, DIR_RIGHT, 16'hFFFF, 1'b0));
      enqueue_request(make_request(OP_EXCHANGE, 0, 0, DIR_LEFT, 16'h0000, 1'b1));
      enqueue_request(make_request(OP_EXCHANGE, 0, 63, DIR_WITH, 16'h8000, 1'b0));
      enqueue_request(make_request(OP_WRITE, 63, 5, DIR_RIGHT, 16'h0000, 1'b1));
      enqueue_request(make_request(OP_EXCHANGE, 63, 5, DIR_WITH, 16'hFFFF, 1'b0));
      enqueue_request(make_request(OP_EXCHANGE, 0, 5, DIR_AGAINST, 16'h0001, 1'b0));
      enqueue_request(make_request(OP_EXCHANGE, 10, 10, DIR_WITH, 16'h0000, 1'b0));
      enqueue_request(make_request(OP_WRITE, 3, 2, DIR_RIGHT, 16'h0000, 1'b1));
      enqueue_request(make_request(OP_EXCHANGE, 2, 2, DIR_AGAINST, 16'h1234, 1'b0));
      enqueue_request(make_request(OP_EXCHANGE, 0, 0, DIR_WITH, 16'h0000, 1'b0));
      enqueue_request(make_request(OP_WRITE, 63, 0, DIR_WITH, 16'h0000, 1'b1));
      enqueue_request(make_request(OP_EXCHANGE, 63, 0, DIR_LEFT, 16'hFFFF, 1'b0));
      enqueue_request(make_request(OP_UNUSED, 63, 63, DIR_WITH, 16'h0000, 1'b0));
      enqueue_request(make_request(OP_WRITE, 63, 63, DIR_AGAINST, 16'hFFFF, 1'b0));
      enqueue_request(make_request(OP_READ, 63, 63, DIR_LEFT, 16'hAAAA, 1'b1));

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         if (phase > 0)
            settle_block();
         case (phase)
            1: program_factors('0, '0, '0, '0, '0, '0, '0, '0);
            2: program_factors('1, '1, '1, '1, '1, '1, '1, '1);
            // moderate temperature with a downward drive
            3: program_factors(ONE_Q16, ONE_Q16, ONE_Q16, 32'h0000_4DA7, 32'h0000_1778,
                               32'h0000_0727, 32'h0002_0000, 32'h0000_8000);
            4: program_factors($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom);
            5: program_factors($urandom_range(0, 32'h1FFFF), $urandom_range(0, 32'h1FFFF),
                               $urandom_range(0, 32'h1FFFF), $urandom_range(0, 32'h1FFFF),
                               $urandom_range(0, 32'h1FFFF), $urandom_range(0, 32'h1FFFF),
                               $urandom_range(0, 32'h1FFFF), $urandom_range(0, 32'h1FFFF));
            default: ;
         endcase
         sender_gap_max = gap_limit_by_phase[phase];
         receiver_stall_max = stall_limit_by_phase[phase];
         queue_random_items(ITEMS_PER_PHASE);
      end

      settle_block();
      if (mismatch_count == 0 && awaited_site_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
